/* rtl/rpd_pkg.sv */
// ----------------------------------------------------------------------------
// rpd_pkg: shared types for the request pool allocator
// Opcodes, result codes, slot descriptor, search beat and slot write commands.
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

  typedef enum logic [1:0] {
    OP_MAKE  = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    STAT_CREATED   = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FREED     = 3'd3,
    STAT_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLAIM,
    WR_WIPE,
    WR_WIPE_ALL
  } wr_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic [15:0] device_id;
    logic [7:0]  request_type;
    logic [7:0]  request_flags;
    logic [31:0] device_number;
    logic [15:0] handler_id;
  } desc_t;

  // search beat walking down the cell row
  typedef struct packed {
    logic valid;
    logic dup;
    logic found;
  } wave_t;

endpackage

`default_nettype wire

/* rtl/rpd_cell.sv */
// ----------------------------------------------------------------------------
// rpd_cell: one pool slot
// Holds the taken mark and descriptor, folds its compare and free check into
// the passing search beat and registers the beat for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_cell #(
  parameter int IdxW    = 3,
  parameter int CellIdx = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpd_pkg::desc_t    desc_i,
  input  wire rpd_pkg::wave_t    wave_i,
  input  wire logic [IdxW-1:0]   idx_i,
  input  wire rpd_pkg::wr_op_e   wr_op_i,
  input  wire logic [IdxW-1:0]   wr_idx_i,
  output rpd_pkg::wave_t         wave_o,
  output logic [IdxW-1:0]        idx_o
);
  import rpd_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic            taken_q, taken_d;
  desc_t           desc_q, desc_d;
  wave_t           wave_q, wave_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hit;
  logic            match;

  assign hit   = (wr_idx_i == MyIdx);
  assign match = taken_q && (desc_q == desc_i);

  always_comb begin
    taken_d = taken_q;
    desc_d  = desc_q;
    case (wr_op_i)
      WR_CLAIM: begin
        if (hit) begin
          taken_d = 1'b1;
          desc_d  = desc_i;
        end
      end
      WR_WIPE: begin
        if (hit) taken_d = 1'b0;
      end
      WR_WIPE_ALL: taken_d = 1'b0;
      default: ;
    endcase
  end

  // keep the first free index seen upstream, else offer this slot
  always_comb begin
    wave_d.valid = wave_i.valid;
    wave_d.dup   = wave_i.dup | match;
    wave_d.found = wave_i.found | ~taken_q;
    idx_d        = wave_i.found ? idx_i : MyIdx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
      wave_q  <= '0;
    end else begin
      taken_q <= taken_d;
      wave_q  <= wave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    idx_q  <= idx_d;
  end

  assign wave_o = wave_q;
  assign idx_o  = idx_q;

endmodule

`default_nettype wire

/* rtl/request_pool_dedup_allocator.sv */
// ----------------------------------------------------------------------------
// request_pool_dedup_allocator: slot pool with duplicate check
// Fixed pool of request slots held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. Opcode
//   make searches the pool: a search beat walks the cell row one slot per
//   cycle, gathering a duplicate flag and the lowest free slot; if there is
//   no duplicate and a slot is free, the descriptor is written to it. Free
//   releases one slot, clear wipes all slots.
//   Each accepted command with a defined opcode yields one result beat on
//   status_o/slot_o/slot_valid_o, marked by done_o for one cycle. The
//   receiver cannot stall; the result is simply presented.
//   Make: the search beat passes every cell register in turn, and busy
//   stays high until done_o rises, so the walk through the cell row sets the
//   pace; the next command can be taken while done_o is high. Free and clear
//   answer from the exec state. The unused opcode gives no result.
//   Reset empties the pool at once; no sweep is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module request_pool_dedup_allocator #(
  parameter int POOL_SIZE = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [15:0] device_id_i,
  input  wire logic [7:0]  request_type_i,
  input  wire logic [7:0]  request_flags_i,
  input  wire logic [31:0] device_number_i,
  input  wire logic [15:0] handler_id_i,
  input  wire logic [2:0]  slot_index_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [2:0]       slot_o,
  output logic             slot_valid_o
);
  import rpd_pkg::*;

  localparam int IdxW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  state_e          state_q, state_d;
  logic [1:0]      cmd_op_q;
  desc_t           cmd_desc_q;
  logic [2:0]      cmd_idx_q;

  logic            done_q, done_d;
  status_e         status_q, status_d;
  logic [2:0]      slot_q, slot_d;
  logic            slot_valid_q, slot_valid_d;

  wave_t           wave [POOL_SIZE+1];
  logic [IdxW-1:0] widx [POOL_SIZE+1];
  wr_op_e          wr_op;
  logic [IdxW-1:0] wr_idx;
  logic            launch;
  logic            accept;
  logic            free_ok;

  assign accept  = start && (state_q == ST_IDLE);
  assign free_ok = (32'(cmd_idx_q) < POOL_SIZE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_op_q                 <= opcode_i;
      cmd_desc_q.device_id     <= device_id_i;
      cmd_desc_q.request_type  <= request_type_i;
      cmd_desc_q.request_flags <= request_flags_i;
      cmd_desc_q.device_number <= device_number_i;
      cmd_desc_q.handler_id    <= handler_id_i;
      cmd_idx_q                <= slot_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    slot_q       <= slot_d;
    slot_valid_q <= slot_valid_d;
  end

  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    status_d     = status_q;
    slot_d       = slot_q;
    slot_valid_d = slot_valid_q;
    wr_op        = WR_NONE;
    wr_idx       = '0;
    launch       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (opcode_e'(cmd_op_q))
          OP_MAKE: begin
            // launch the search beat into the first cell
            launch  = 1'b1;
            state_d = ST_WAIT;
          end
          OP_FREE: begin
            if (free_ok) wr_op = WR_WIPE;
            wr_idx       = IdxW'(cmd_idx_q);
            done_d       = 1'b1;
            status_d     = STAT_FREED;
            slot_d       = cmd_idx_q;
            slot_valid_d = free_ok;
          end
          OP_CLEAR: begin
            wr_op        = WR_WIPE_ALL;
            done_d       = 1'b1;
            status_d     = STAT_CLEARED;
            slot_d       = '0;
            slot_valid_d = 1'b0;
          end
          default: ;
        endcase
      end
      ST_WAIT: begin
        if (wave[POOL_SIZE].valid) begin
          state_d      = ST_IDLE;
          done_d       = 1'b1;
          slot_d       = '0;
          slot_valid_d = 1'b0;
          if (wave[POOL_SIZE].dup) begin
            status_d = STAT_DUPLICATE;
          end else if (wave[POOL_SIZE].found) begin
            wr_op        = WR_CLAIM;
            wr_idx       = widx[POOL_SIZE];
            status_d     = STAT_CREATED;
            slot_d       = 3'(widx[POOL_SIZE]);
            slot_valid_d = 1'b1;
          end else begin
            status_d = STAT_FULL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign wave[0] = '{valid: launch, dup: 1'b0, found: 1'b0};
  assign widx[0] = '0;

  for (genvar k = 0; k < POOL_SIZE; k++) begin : g_cell
    rpd_cell #(
      .IdxW    (IdxW),
      .CellIdx (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .desc_i   (cmd_desc_q),
      .wave_i   (wave[k]),
      .idx_i    (widx[k]),
      .wr_op_i  (wr_op),
      .wr_idx_i (wr_idx),
      .wave_o   (wave[k+1]),
      .idx_o    (widx[k+1])
    );
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign slot_valid_o = slot_valid_q;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: request pool allocator bench
// Feeds make, free, clear and unused opcodes to the pool, keeps a shadow
// copy of every slot to work out each reply, and compares done_o beats
// against the replies due in order of acceptance.
// ----------------------------------------------------------------------------

module tb_top;
  import rpd_pkg::*;

  localparam int POOL_SIZE = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [31:0] DEVNUM_IDLE = 32'hFF;
  localparam int RANDOM_CMDS = 900;
  localparam int SETTLE_CYCLES = 4 * (POOL_SIZE + 2);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0] op;
    desc_t      desc;
    logic [2:0] idx;
    bit         drain;
  } pool_cmd_t;

  typedef struct {
    status_e    status;
    logic [2:0] slot;
    logic       valid;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = '0;
  logic [15:0] device_id_i = '0;
  logic [7:0]  request_type_i = '0;
  logic [7:0]  request_flags_i = '0;
  logic [31:0] device_number_i = '0;
  logic [15:0] handler_id_i = '0;
  logic [2:0]  slot_index_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [2:0]  slot_o;
  logic        slot_valid_o;

  pool_cmd_t cmd_backlog[$];
  reply_t    replies_due[$];
  pool_cmd_t cur_cmd;
  int        sent_cnt = 0;
  int        errors = 0;
  int        cycles = 0;

  // shadow copy of the pool
  bit    slot_held[POOL_SIZE];
  desc_t slot_desc[POOL_SIZE];

  request_pool_dedup_allocator #(
    .POOL_SIZE(POOL_SIZE)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .device_id_i    (device_id_i),
    .request_type_i (request_type_i),
    .request_flags_i(request_flags_i),
    .device_number_i(device_number_i),
    .handler_id_i   (handler_id_i),
    .slot_index_i   (slot_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .slot_valid_o   (slot_valid_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void wipe_slot(input int s);
    slot_held[s] = 1'b0;
    slot_desc[s] = '0;
    slot_desc[s].device_number = DEVNUM_IDLE;
  endfunction

  // apply one command to the shadow pool; returns 0 when no reply follows
  function automatic bit pool_apply(input pool_cmd_t c, output reply_t r);
    int hit;
    int free_slot;
    hit = -1;
    free_slot = -1;
    r.status = STAT_CLEARED;
    r.slot = 3'd0;
    r.valid = 1'b0;
    case (c.op)
      OP_MAKE: begin
        for (int s = 0; s < POOL_SIZE; s++) begin
          if (slot_held[s] && slot_desc[s] == c.desc && hit < 0) hit = s;
          if (!slot_held[s] && free_slot < 0) free_slot = s;
        end
        if (hit >= 0) begin
          r.status = STAT_DUPLICATE;
        end else if (free_slot >= 0) begin
          slot_held[free_slot] = 1'b1;
          slot_desc[free_slot] = c.desc;
          r.status = STAT_CREATED;
          r.slot = 3'(free_slot);
          r.valid = 1'b1;
        end else begin
          r.status = STAT_FULL;
        end
        return 1'b1;
      end
      OP_FREE: begin
        r.status = STAT_FREED;
        r.slot = c.idx;
        if (int'(c.idx) < POOL_SIZE) begin
          wipe_slot(int'(c.idx));
          r.valid = 1'b1;
        end
        return 1'b1;
      end
      OP_CLEAR: begin
        for (int s = 0; s < POOL_SIZE; s++) wipe_slot(s);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void cmd_push(input logic [1:0] op, input desc_t d,
                                   input logic [2:0] idx, input bit drain);
    pool_cmd_t c;
    c.op = op;
    c.desc = d;
    c.idx = idx;
    c.drain = drain;
    cmd_backlog.push_back(c);
  endfunction

  // flip one bit of one descriptor part
  function automatic desc_t flip_bit(input desc_t d, input int part, input int b);
    case (part)
      0: d.device_id = d.device_id ^ (16'd1 << (b % 16));
      1: d.request_type = d.request_type ^ (8'd1 << (b % 8));
      2: d.request_flags = d.request_flags ^ (8'd1 << (b % 8));
      3: d.device_number = d.device_number ^ (32'd1 << (b % 32));
      default: d.handler_id = d.handler_id ^ (16'd1 << (b % 16));
    endcase
    return d;
  endfunction

  function automatic desc_t rand_desc();
    desc_t d;
    d.device_id = 16'($urandom);
    d.request_type = 8'($urandom);
    d.request_flags = 8'($urandom);
    d.device_number = $urandom;
    d.handler_id = 16'($urandom);
    return d;
  endfunction

  always @(posedge clk_i) begin : drive_cmds
    pool_cmd_t nxt;
    reply_t    r;
    bit        took;
    bit        go;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        if (pool_apply(cur_cmd, r)) replies_due.push_back(r);
        sent_cnt++;
      end
      if (!start || took) begin
        go = 1'b0;
        if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog[0];
          // hold a drain beat until the pool has answered everything
          if (nxt.drain && replies_due.size() != 0) go = 1'b0;
          else if (!(sent_cnt >= 350 && sent_cnt < 550) && $urandom_range(0, 99) < 29)
            go = 1'b0;
          else go = 1'b1;
        end
        if (go) begin
          void'(cmd_backlog.pop_front());
          cur_cmd = nxt;
          opcode_i <= nxt.op;
          device_id_i <= nxt.desc.device_id;
          request_type_i <= nxt.desc.request_type;
          request_flags_i <= nxt.desc.request_flags;
          device_number_i <= nxt.desc.device_number;
          handler_id_i <= nxt.desc.handler_id;
          slot_index_i <= nxt.idx;
        end
        start <= go;
      end
    end
  end

  always @(posedge clk_i) begin : check_replies
    reply_t e;
    if (rst_ni && done_o === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual status %0d slot %0d valid %0d",
                 $time, status_o, slot_o, slot_valid_o);
        errors++;
      end else begin
        e = replies_due.pop_front();
        if ({status_o, slot_o, slot_valid_o} !== {e.status, e.slot, e.valid}) begin
          $display("%0t: reply mismatch: expected status %0d slot %0d valid %0d, actual status %0d slot %0d valid %0d",
                   $time, e.status, e.slot, e.valid, status_o, slot_o, slot_valid_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    desc_t     ones;
    desc_t     zero_desc;
    desc_t     idle_desc;
    desc_t     d;
    desc_t     recent[$];
    int        made;
    int        pick;
    logic [1:0] op;
    for (int s = 0; s < POOL_SIZE; s++) wipe_slot(s);
    ones = '1;
    zero_desc = '0;
    idle_desc = '0;
    idle_desc.device_number = DEVNUM_IDLE;

    // directed: empty pool, wiped-slot look-alikes, near duplicates, full pool
    cmd_push(OP_CLEAR, zero_desc, 3'd0, 1'b0);
    cmd_push(OP_FREE, zero_desc, 3'd3, 1'b0);
    cmd_push(OP_MAKE, idle_desc, 3'd0, 1'b0);
    cmd_push(OP_MAKE, idle_desc, 3'd0, 1'b0);
    cmd_push(OP_MAKE, zero_desc, 3'd0, 1'b0);
    cmd_push(OP_MAKE, ones, 3'd7, 1'b0);
    cmd_push(OP_MAKE, ones, 3'd7, 1'b0);
    cmd_push(OP_UNUSED, ones, 3'd7, 1'b0);
    for (int p = 0; p < 5; p++) cmd_push(OP_MAKE, flip_bit(ones, p, 0), 3'd0, 1'b0);
    cmd_push(OP_MAKE, rand_desc(), 3'd0, 1'b0);
    cmd_push(OP_MAKE, ones, 3'd0, 1'b0);
    cmd_push(OP_FREE, ones, 3'd7, 1'b0);
    cmd_push(OP_FREE, zero_desc, 3'd0, 1'b0);
    cmd_push(OP_MAKE, flip_bit(ones, 4, 0), 3'd0, 1'b0);
    cmd_push(OP_MAKE, zero_desc, 3'd0, 1'b0);
    cmd_push(OP_MAKE, rand_desc(), 3'd0, 1'b0);
    cmd_push(OP_FREE, zero_desc, 3'd7, 1'b1);
    cmd_push(OP_CLEAR, ones, 3'd7, 1'b0);
    cmd_push(OP_MAKE, ones, 3'd0, 1'b0);

    // random: makes mostly reuse recent descriptors so duplicates and
    // one-bit near misses come up often; unused opcodes do not count
    made = 0;
    while (made < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) op = OP_MAKE;
      else if (pick < 90) op = OP_FREE;
      else if (pick < 94) op = OP_CLEAR;
      else op = OP_UNUSED;
      pick = $urandom_range(0, 99);
      if (recent.size() != 0 && pick < 35) begin
        d = recent[$urandom_range(0, recent.size() - 1)];
      end else if (recent.size() != 0 && pick < 60) begin
        d = flip_bit(recent[$urandom_range(0, recent.size() - 1)],
                     $urandom_range(0, 4), $urandom_range(0, 31));
      end else begin
        d = rand_desc();
        recent.push_back(d);
        if (recent.size() > 12) void'(recent.pop_front());
      end
      cmd_push(op, d, 3'($urandom_range(0, 7)),
               made == 100 || made == 450 || made == 800);
      if (op != OP_UNUSED) made++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || start || replies_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rpd_pkg.sv
rtl/rpd_cell.sv
rtl/request_pool_dedup_allocator.sv
bench/tb_top.sv
